// ----- sv/owf_pkg.sv -----
// ============================================================================
// owf_pkg: shared types and constants of the overlapped window framer
// Item and result words, the job word that passes from the front end to the
// back end, queue sizes and the fixed-point limits of the weighting stage.
// ============================================================================
package owf_pkg;

    // Window geometry and data widths.
    localparam int WINDOW_LENGTH = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 14;
    localparam int DATA_BITS     = 16;
    localparam int SLOT_BITS     = 6;
    localparam int POS_BITS      = 6;
    localparam int HOP_BITS      = 7;
    localparam int IDX_BITS      = $clog2(WINDOW_LENGTH);
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;

    localparam logic [HOP_BITS-1:0] HOP_RESET = HOP_BITS'(8);

    // Saturation limits of a weighted sample, held at product width.
    localparam logic signed [PROD_BITS-1:0] SAT_MAX =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SAT_MIN = -SAT_MAX - PROD_BITS'(1);

    // Queue sizes. Both depths are powers of two so the pointers wrap freely.
    localparam int JQ_DEPTH    = 4;
    localparam int JQ_PTR_BITS = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_BITS = $clog2(JQ_DEPTH + 1);
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_BITS = $clog2(RQ_DEPTH + 1);

    // Item operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                        op;
        logic signed [DATA_BITS-1:0] sample_in;
        logic [SLOT_BITS-1:0]        coef_slot;
        logic signed [DATA_BITS-1:0] coef_value;
    } owf_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] weighted_sample;
        logic [POS_BITS-1:0]           position;
        logic                          last;
    } owf_result_t;

    typedef enum logic {
        JOB_SAMPLE,
        JOB_LOAD
    } owf_job_kind_t;

    typedef struct packed {
        owf_job_kind_t               kind;
        logic signed [DATA_BITS-1:0] data;
        logic [IDX_BITS-1:0]         slot;
    } owf_job_t;

    typedef struct packed {
        logic     valid;
        owf_job_t job;
    } owf_job_head_t;

endpackage

// ----- sv/owf_front.sv -----
// ============================================================================
// owf_front: item intake and job queue
// Accepts item words, decodes them into sample or load jobs, drops loads
// aimed beyond the window, and buffers the jobs for the back end.
// ============================================================================
module owf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  owf_pkg::owf_item_t     item,
    output owf_pkg::owf_job_head_t head,
    input  logic                   take
);

    owf_pkg::owf_job_t                 q_mem [owf_pkg::JQ_DEPTH];
    logic [owf_pkg::JQ_PTR_BITS-1:0]   wr_ptr_reg;
    logic [owf_pkg::JQ_PTR_BITS-1:0]   rd_ptr_reg;
    logic [owf_pkg::JQ_CNT_BITS-1:0]   count_reg;
    logic [owf_pkg::JQ_CNT_BITS-1:0]   count_next;
    logic                              accept;
    logic                              slot_ok;
    logic                              do_wr;
    logic                              do_rd;
    owf_pkg::owf_job_t                 job;

    assign full    = (count_reg == owf_pkg::JQ_CNT_BITS'(owf_pkg::JQ_DEPTH));
    assign accept  = push && !full;
    assign slot_ok = ({1'b0, item.coef_slot} <
                      (owf_pkg::SLOT_BITS + 1)'(owf_pkg::WINDOW_LENGTH));

    // A load to a slot outside the window has no effect, so it never
    // enters the queue.
    assign do_wr = accept && ((item.op == owf_pkg::OP_SAMPLE) || slot_ok);
    assign do_rd = take && (count_reg != '0);

    always_comb
    begin
        job.kind = (item.op == owf_pkg::OP_LOAD) ? owf_pkg::JOB_LOAD : owf_pkg::JOB_SAMPLE;
        job.data = (item.op == owf_pkg::OP_LOAD) ? item.coef_value : item.sample_in;
        job.slot = item.coef_slot[owf_pkg::IDX_BITS-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + owf_pkg::JQ_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - owf_pkg::JQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + owf_pkg::JQ_PTR_BITS'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + owf_pkg::JQ_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= job;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.job   = q_mem[rd_ptr_reg];

endmodule

// ----- sv/owf_result_queue.sv -----
// ============================================================================
// owf_result_queue: result word buffer
// Holds weighted samples until the consumer pops them and reports its fill
// level so the back end only starts words that are sure to find room.
// ============================================================================
module owf_result_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  owf_pkg::owf_result_t            wr_word,
    input  logic                            pop,
    output logic                            empty,
    output owf_pkg::owf_result_t            result,
    output logic [owf_pkg::RQ_CNT_BITS-1:0] count
);

    owf_pkg::owf_result_t              q_mem [owf_pkg::RQ_DEPTH];
    logic [owf_pkg::RQ_PTR_BITS-1:0]   wr_ptr_reg;
    logic [owf_pkg::RQ_PTR_BITS-1:0]   rd_ptr_reg;
    logic [owf_pkg::RQ_CNT_BITS-1:0]   count_reg;
    logic [owf_pkg::RQ_CNT_BITS-1:0]   count_next;
    logic                              do_rd;

    assign empty = (count_reg == '0);
    assign do_rd = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + owf_pkg::RQ_CNT_BITS'(1);
        end
        else if (do_rd && !wr_en)
        begin
            count_next = count_reg - owf_pkg::RQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + owf_pkg::RQ_PTR_BITS'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + owf_pkg::RQ_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= wr_word;
        end
    end

    assign result = q_mem[rd_ptr_reg];
    assign count  = count_reg;

endmodule

// ----- sv/owf_back.sv -----
// ============================================================================
// owf_back: window sequencer and weighting datapath
// Executes jobs in order: loads write the coefficient table, samples shift
// the delay line and count the hop. A completed hop starts a sweep over the
// window through a read stage, a multiply stage and saturation.
// ============================================================================
module owf_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  owf_pkg::owf_job_head_t          head,
    output logic                            take,
    input  logic [owf_pkg::RQ_CNT_BITS-1:0] rq_count,
    output logic                            rq_wr,
    output owf_pkg::owf_result_t            rq_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owf_pkg::HOP_BITS-1:0]    cfg_data
);

    typedef enum logic {
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;
    logic [owf_pkg::IDX_BITS-1:0]            idx_reg;
    logic [owf_pkg::IDX_BITS-1:0]            idx_next;
    logic [owf_pkg::HOP_BITS-1:0]            hop_cnt_reg;
    logic [owf_pkg::HOP_BITS-1:0]            hop_cnt_next;
    logic [owf_pkg::HOP_BITS-1:0]            hop_len_reg;
    logic [owf_pkg::HOP_BITS-1:0]            hop_eff;
    logic [owf_pkg::HOP_BITS-1:0]            cnt_inc;
    logic                                    shift_en;
    logic                                    load_en;
    logic                                    issue;
    logic [owf_pkg::RQ_CNT_BITS:0]           pending;

    logic signed [owf_pkg::SAMPLE_BITS-1:0]  hist_reg [owf_pkg::WINDOW_LENGTH];
    logic signed [owf_pkg::COEF_BITS-1:0]    table_mem [owf_pkg::WINDOW_LENGTH];

    logic                                    s1_valid_reg;
    logic signed [owf_pkg::SAMPLE_BITS-1:0]  hist_rd_reg;
    logic signed [owf_pkg::COEF_BITS-1:0]    coef_rd_reg;
    logic [owf_pkg::IDX_BITS-1:0]            s1_pos_reg;
    logic                                    s1_last_reg;
    logic                                    s2_valid_reg;
    logic signed [owf_pkg::PROD_BITS-1:0]    prod_reg;
    logic [owf_pkg::IDX_BITS-1:0]            s2_pos_reg;
    logic                                    s2_last_reg;
    logic signed [owf_pkg::PROD_BITS-1:0]    shifted;
    logic signed [owf_pkg::SAMPLE_BITS-1:0]  weighted;

    assign cfg_ready = 1'b1;

    assign hop_eff = (hop_len_reg == '0) ? owf_pkg::HOP_BITS'(1) : hop_len_reg;
    assign cnt_inc = hop_cnt_reg + owf_pkg::HOP_BITS'(1);

    // Words in flight plus words already queued; a new word starts only
    // when all of them are sure to fit in the result queue.
    assign pending = (owf_pkg::RQ_CNT_BITS + 1)'(rq_count)
                   + (owf_pkg::RQ_CNT_BITS + 1)'(s1_valid_reg)
                   + (owf_pkg::RQ_CNT_BITS + 1)'(s2_valid_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hop_cnt_next = hop_cnt_reg;
        take         = 1'b0;
        shift_en     = 1'b0;
        load_en      = 1'b0;
        issue        = 1'b0;
        unique case (state_reg)
            ST_FETCH:
            begin
                if (head.valid)
                begin
                    take = 1'b1;
                    if (head.job.kind == owf_pkg::JOB_LOAD)
                    begin
                        load_en = 1'b1;
                    end
                    else
                    begin
                        shift_en = 1'b1;
                        if (cnt_inc < hop_eff)
                        begin
                            hop_cnt_next = cnt_inc;
                        end
                        else
                        begin
                            hop_cnt_next = '0;
                            idx_next     = '0;
                            state_next   = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (pending < (owf_pkg::RQ_CNT_BITS + 1)'(owf_pkg::RQ_DEPTH))
                begin
                    issue = 1'b1;
                    if (idx_reg == owf_pkg::IDX_BITS'(owf_pkg::WINDOW_LENGTH - 1))
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        idx_next = idx_reg + owf_pkg::IDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FETCH;
            idx_reg      <= '0;
            hop_cnt_reg  <= '0;
            hop_len_reg  <= owf_pkg::HOP_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            hop_cnt_reg  <= hop_cnt_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_valid)
            begin
                hop_len_reg <= cfg_data;
            end
        end
    end

    // The delay line starts as silence, so it is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < owf_pkg::WINDOW_LENGTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int i = 0; i < owf_pkg::WINDOW_LENGTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i + 1];
            end
            hist_reg[owf_pkg::WINDOW_LENGTH - 1] <= owf_pkg::SAMPLE_BITS'(head.job.data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            table_mem[head.job.slot] <= owf_pkg::COEF_BITS'(head.job.data);
        end
        if (issue)
        begin
            coef_rd_reg <= table_mem[idx_reg];
            hist_rd_reg <= hist_reg[idx_reg];
            s1_pos_reg  <= idx_reg;
            s1_last_reg <= (idx_reg == owf_pkg::IDX_BITS'(owf_pkg::WINDOW_LENGTH - 1));
        end
        if (s1_valid_reg)
        begin
            prod_reg    <= hist_rd_reg * coef_rd_reg;
            s2_pos_reg  <= s1_pos_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // The arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        shifted = prod_reg >>> owf_pkg::COEF_FRAC;
        if (shifted > owf_pkg::SAT_MAX)
        begin
            weighted = owf_pkg::SAMPLE_BITS'(owf_pkg::SAT_MAX);
        end
        else if (shifted < owf_pkg::SAT_MIN)
        begin
            weighted = owf_pkg::SAMPLE_BITS'(owf_pkg::SAT_MIN);
        end
        else
        begin
            weighted = shifted[owf_pkg::SAMPLE_BITS-1:0];
        end
    end

    assign rq_wr                   = s2_valid_reg;
    assign rq_word.weighted_sample = weighted;
    assign rq_word.position        = owf_pkg::POS_BITS'(s2_pos_reg);
    assign rq_word.last            = s2_last_reg;

endmodule

// ----- sv/overlapped_window_framer.sv -----
// A sample that completes a hop goes through the job queue, the emit state, the read and
// multiply stages and the result queue. The back end takes no job during the sweep, which
// emits one window word per cycle while there is room, set by the single multiplier pipeline.
// Reset clears the delay line, hop counter and both queues and sets hop_length to 8;
// the coefficient table is not cleared and must be loaded before windows are emitted.
// ============================================================================
// overlapped_window_framer: windowed framing of a sample stream
// Keeps the most recent window of samples and, once per hop, emits the whole
// window weighted by a loadable Q2.14 coefficient table, oldest word first.
// ============================================================================
module overlapped_window_framer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  owf_pkg::owf_item_t           item,
    output logic                         empty,
    input  logic                         pop,
    output owf_pkg::owf_result_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [owf_pkg::HOP_BITS-1:0] cfg_data
);

    owf_pkg::owf_job_head_t            head;
    logic                              take;
    logic                              rq_wr;
    owf_pkg::owf_result_t              rq_word;
    logic [owf_pkg::RQ_CNT_BITS-1:0]   rq_count;

    owf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .head  (head),
        .take  (take)
    );

    owf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .take      (take),
        .rq_count  (rq_count),
        .rq_wr     (rq_wr),
        .rq_word   (rq_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    owf_result_queue u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_wr),
        .wr_word (rq_word),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .count   (rq_count)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the overlapped window framer
// Drives sample and coefficient-load words through the input queue under
// random gaps, steps a predictor of the delay line, hop counter and
// coefficient table, and checks every window word popped from the block
// against it. The hop length is changed between phases, only while idle.
// ============================================================================
module tb;

    // Predicts the window words of the framer and checks them in order.
    class window_checker;
        logic signed [owf_pkg::DATA_BITS-1:0] history [owf_pkg::WINDOW_LENGTH];
        logic signed [owf_pkg::COEF_BITS-1:0] coefs [owf_pkg::WINDOW_LENGTH];
        logic [owf_pkg::HOP_BITS-1:0]         hop_count;
        logic [owf_pkg::HOP_BITS-1:0]         hop_len;
        owf_pkg::owf_result_t                 expected_words [$];
        int                                   errors;

        function new();
            foreach (history[k]) history[k] = '0;
            foreach (coefs[k]) coefs[k] = '0;
            hop_count = '0;
            hop_len   = owf_pkg::HOP_RESET;
            errors    = 0;
        endfunction

        function void set_hop(logic [owf_pkg::HOP_BITS-1:0] h);
            hop_len = h;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Q2.14 weighting: floor of the product over 2^14, then saturation.
        function logic signed [owf_pkg::SAMPLE_BITS-1:0] scale_by_coef(
            logic signed [owf_pkg::DATA_BITS-1:0] s,
            logic signed [owf_pkg::COEF_BITS-1:0] c);
            int prod;
            int q;
            prod = int'(s) * int'(c);
            q = prod >>> owf_pkg::COEF_FRAC;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[owf_pkg::SAMPLE_BITS-1:0];
        endfunction

        function void note_item(owf_pkg::owf_item_t w);
            logic [owf_pkg::HOP_BITS-1:0] eff_hop;
            owf_pkg::owf_result_t         r;
            if (w.op == owf_pkg::OP_LOAD)
            begin
                if (w.coef_slot < owf_pkg::WINDOW_LENGTH)
                    coefs[w.coef_slot] = w.coef_value;
                return;
            end
            for (int k = 0; k < owf_pkg::WINDOW_LENGTH - 1; k++)
                history[k] = history[k + 1];
            history[owf_pkg::WINDOW_LENGTH - 1] = w.sample_in;
            eff_hop   = (hop_len == 0) ? owf_pkg::HOP_BITS'(1) : hop_len;
            hop_count = hop_count + 1'b1;
            if (hop_count < eff_hop)
                return;
            hop_count = '0;
            for (int k = 0; k < owf_pkg::WINDOW_LENGTH; k++)
            begin
                r.weighted_sample = scale_by_coef(history[k], coefs[k]);
                r.position        = owf_pkg::POS_BITS'(k);
                r.last            = (k == owf_pkg::WINDOW_LENGTH - 1);
                expected_words.push_back(r);
            end
        endfunction

        function void check_word(owf_pkg::owf_result_t r);
            owf_pkg::owf_result_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: weighted_sample %0d position %0d last %0d",
                       r.weighted_sample, r.position, r.last);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (r.weighted_sample !== e.weighted_sample)
            begin
                $error("weighted_sample: expected %0d, got %0d", e.weighted_sample,
                       r.weighted_sample);
                errors++;
            end
            if (r.position !== e.position)
            begin
                $error("position: expected %0d, got %0d", e.position, r.position);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         push      = 1'b0;
    logic                         full;
    owf_pkg::owf_item_t           item_word = '0;
    logic                         empty;
    logic                         pop       = 1'b0;
    owf_pkg::owf_result_t         result;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [owf_pkg::HOP_BITS-1:0] cfg_data  = '0;

    // When set, neither side inserts gaps.
    bit steady = 1'b0;

    window_checker board = new();

    int phase_hop [7] = '{0, 127, 1, 64, 32, 8, 8};
    int phase_len [7] = '{20, 140, 20, 70, 60, 35, 35};

    overlapped_window_framer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item_word),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic owf_pkg::owf_item_t build_item(logic op, logic [15:0] smp,
                                                      logic [5:0] slot, logic [15:0] coef);
        owf_pkg::owf_item_t w;
        w.op         = op;
        w.sample_in  = smp;
        w.coef_slot  = slot;
        w.coef_value = coef;
        return w;
    endfunction

    // Mostly uniform values, with the two extremes showing up often.
    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic owf_pkg::owf_item_t random_item();
        logic [5:0] slot;
        slot = ($urandom_range(0, 3) == 0)
             ? 6'($urandom_range(owf_pkg::WINDOW_LENGTH, 63))
             : 6'($urandom_range(0, owf_pkg::WINDOW_LENGTH - 1));
        return build_item(($urandom_range(0, 99) < 15) ? owf_pkg::OP_LOAD : owf_pkg::OP_SAMPLE,
                          rand_value(), slot, rand_value());
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input owf_pkg::owf_item_t w);
        int gap;
        gap = 0;
        while (!steady && gap < 8 && $urandom_range(0, 99) < 33)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        item_word <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_item(w);
    endtask

    // Words that produce no output may still be in flight once the last
    // window word is out, so wait a while longer before touching the register.
    task automatic write_hop(input logic [owf_pkg::HOP_BITS-1:0] h);
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_hop(h);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                board.check_word(result);
            pop <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin
        logic [15:0] edge_samples [8];
        edge_samples = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
                         16'hAAAA, 16'h4000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every coefficient is loaded before the first window can be emitted.
        for (int k = 0; k < owf_pkg::WINDOW_LENGTH; k++)
        begin
            case (k)
                0: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k), 16'h8000));
                1: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k), 16'h7FFF));
                2: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k), 16'h4000));
                3: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k), 16'h0000));
                4: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k), 16'hFFFF));
                default: send_word(build_item(owf_pkg::OP_LOAD, 16'($urandom), 6'(k),
                                              rand_value()));
            endcase
        end
        // Loads beyond the window are ignored.
        send_word(build_item(owf_pkg::OP_LOAD, 16'h7FFF, 6'(owf_pkg::WINDOW_LENGTH), 16'h0000));
        send_word(build_item(owf_pkg::OP_LOAD, 16'h8000, 6'd63, 16'h7FFF));
        // Extreme samples at the reset hop, with a load landing between two hops.
        for (int k = 0; k < 8; k++)
            send_word(build_item(owf_pkg::OP_SAMPLE, edge_samples[k], 6'($urandom),
                                 16'($urandom)));
        send_word(build_item(owf_pkg::OP_LOAD, 16'h8000, 6'(owf_pkg::WINDOW_LENGTH - 1),
                             16'h8000));
        for (int k = 0; k < 8; k++)
            send_word(build_item(owf_pkg::OP_SAMPLE, edge_samples[7 - k], 6'($urandom),
                                 16'($urandom)));

        // Zero hop, far above range, one, the largest sensible hop, the window
        // itself, a random small hop and back to the reset value.
        phase_hop[5] = $urandom_range(2, 16);
        for (int p = 0; p < 7; p++)
        begin
            write_hop(owf_pkg::HOP_BITS'(phase_hop[p]));
            steady = (p == 4);
            for (int n = 0; n < phase_len[p]; n++)
                send_word(random_item());
        end
        steady = 1'b0;
        push <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
